// ----- design/day_count_calendar_date_unit_macros.svh -----
// Assertion helpers shared by the calendar date unit.
`ifndef DAY_COUNT_CALENDAR_DATE_UNIT_MACROS_SVH
`define DAY_COUNT_CALENDAR_DATE_UNIT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define DCU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication checked outside reset.
`define DCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- design/dcd_pkg.sv -----
package dcd_pkg;
    localparam int CountW = 25;
    localparam logic signed [CountW-1:0] CountMin = -25'sd12687794;
    localparam logic signed [CountW-1:0] CountMax = 25'sd11248737;
    localparam int EpochShift = 719468;
    localparam int EraDays = 146097;
    // Shift of the epoch plus 82 eras, so that no era index is negative.
    localparam int DayBias = 12699422;
    // 82 eras of 400 years, the same bias on the year scale.
    localparam int YearBias = 32800;
    // Reciprocals floor(2^s / d) for s = 25, 18, 18 and 17.
    localparam int EraRecip = 229;
    localparam int Recip1460 = 179;
    localparam int Recip365 = 718;
    localparam int Recip400 = 327;

    localparam logic [1:0] CfgYear  = 2'd0;
    localparam logic [1:0] CfgMonth = 2'd1;
    localparam logic [1:0] CfgDay   = 2'd2;

    typedef struct packed {
        logic load;   // compute count from start date
        logic step;   // add offset to count
        logic conv;   // compute date from count
    } t_cmd;

    typedef struct packed {
        logic done;
    } t_status;

    // Cumulative days before month in a March-based year, index 0 = March.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        unique case (mp)
            4'd0: r = 9'd0;     4'd1: r = 9'd31;    4'd2: r = 9'd61;
            4'd3: r = 9'd92;    4'd4: r = 9'd122;   4'd5: r = 9'd153;
            4'd6: r = 9'd184;   4'd7: r = 9'd214;   4'd8: r = 9'd245;
            4'd9: r = 9'd275;   4'd10: r = 9'd306;  4'd11: r = 9'd337;
            default: r = 9'd366;
        endcase
        return r;
    endfunction
endpackage

// ----- design/dcd_ctrl.sv -----
module dcd_ctrl import dcd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_hit,
    output logic    o_cfg_ready,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_cmd    o_cmd,
    input  t_status i_status
);
    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_LWAIT = 5'b00010,
        S_IDLE  = 5'b00100,
        S_CONV  = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_LOAD;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state = S_LWAIT;
            end
            S_LWAIT: if (i_status.done) n_state = S_IDLE;
            S_IDLE: begin
                if (i_cfg_hit) n_state = S_LOAD;
                else if (i_in_valid) begin
                    o_cmd.step = 1'b1;
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                if (i_status.done) n_state = S_OUT;
            end
            S_OUT: if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_LOAD;
        endcase
    end

    // Register writes are taken only while idle, so a reload is never lost.
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_hit;
    assign o_out_valid = (r_state == S_OUT);
endmodule

// ----- design/dcd_datapath.sv -----
module dcd_datapath import dcd_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic signed [15:0]       i_start_year,
    input  logic [3:0]               i_start_month,
    input  logic [4:0]               i_start_day,
    input  logic signed [23:0]       i_day_offset,
    output logic signed [CountW-1:0] o_day_count,
    output logic signed [15:0]       o_cal_year,
    output logic [3:0]               o_cal_month,
    output logic [4:0]               o_cal_day
);
    function automatic logic [3:0] march_index(input logic [3:0] m);
        return (m > 4'd2) ? m - 4'd3 : m + 4'd9;
    endfunction

    function automatic logic signed [CountW-1:0] clamp(input logic signed [26:0] v);
        if (v < 27'(CountMin)) return CountMin;
        if (v > 27'(CountMax)) return CountMax;
        return 25'(v);
    endfunction

    // Sequencer phases for both conversions.
    logic [3:0]  r_ph;
    logic        r_busy, r_fwd;
    logic signed [CountW-1:0] r_count;
    logic [24:0] r_a;      // biased day or year, later era days
    logic [7:0]  r_q;      // biased era index
    logic [18:0] r_r;      // day of era, or year of era during a load
    logic [8:0]  r_q2;     // partial quotient
    logic [1:0]  r_c;
    logic [11:0] r_rem;
    logic [17:0] r_t;
    logic [8:0]  r_yoe;
    logic [17:0] r_base;
    logic [8:0]  r_doy;
    logic [3:0]  r_mp;
    logic [15:0] r_year;

    logic [3:0]  w_m;
    logic signed [17:0] w_ya;
    logic signed [26:0] w_lsum;
    logic signed [26:0] w_sum;
    logic [25:0] w_q400;
    logic [32:0] w_qera;
    logic [26:0] w_q1460;
    logic [27:0] w_q365;
    logic [1:0]  w_c_doe;
    logic [1:0]  w_c100;
    logic [17:0] w_base;
    logic [3:0]  w_mp;

    assign w_m = (i_start_month < 4'd1) ? 4'd1 :
                 (i_start_month > 4'd12) ? 4'd12 : i_start_month;
    // January and February count with the previous year.
    assign w_ya = 18'(i_start_year) + 18'(YearBias) - ((w_m <= 4'd2) ? 18'sd1 : 18'sd0);
    assign w_lsum = $signed(27'(r_a)) + $signed(27'(month_start(march_index(w_m))))
                  + $signed(27'(i_start_day)) - 27'(DayBias + 1);
    assign w_sum = 27'(r_count) + 27'(i_day_offset);

    // Reciprocal products; one correction step afterwards makes each quotient exact.
    assign w_q400  = 26'(r_a[16:0]) * 26'(Recip400);
    assign w_qera  = 33'(r_a) * 33'(EraRecip);
    assign w_q1460 = 27'(r_r) * 27'(Recip1460);
    assign w_q365  = 28'(r_t) * 28'(Recip365);

    // Whole centuries in the era, less the one at its very last day.
    assign w_c_doe = 2'(r_r >= 19'd36524) + 2'(r_r >= 19'd73048) + 2'(r_r >= 19'd109572);
    assign w_c100  = 2'(r_yoe >= 9'd100) + 2'(r_yoe >= 9'd200) + 2'(r_yoe >= 9'd300);
    assign w_base  = 18'(r_yoe) * 18'd365 + 18'(r_yoe >> 2) - 18'(w_c100);

    always_comb begin
        w_mp = 4'd0;
        for (int k = 1; k < 12; k++)
            if (r_doy >= month_start(4'(k))) w_mp = 4'(k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ph <= '0;
            r_fwd <= 1'b0;
        end else if (i_cmd.load) begin
            r_busy <= 1'b1; r_fwd <= 1'b0; r_ph <= '0;
            r_a <= 25'(w_ya);
        end else if (i_cmd.step) begin
            r_count <= clamp(w_sum);
            r_busy <= 1'b1; r_fwd <= 1'b1; r_ph <= '0;
        end else if (r_busy && !r_fwd) begin
            r_ph <= r_ph + 4'd1;
            unique case (r_ph)
                4'd0: r_q <= 8'(w_q400 >> 17);
                4'd1: r_r <= 19'(r_a - 25'(r_q) * 25'd400);
                4'd2: if (r_r >= 19'd400) begin
                    r_r <= r_r - 19'd400;
                    r_q <= r_q + 8'd1;
                end
                4'd3: r_yoe <= 9'(r_r);
                4'd4: r_base <= w_base;
                4'd5: r_a <= 25'(r_q) * 25'(EraDays) + 25'(r_base);
                4'd6: begin
                    r_count <= clamp(w_lsum);
                    r_busy <= 1'b0;
                end
                default: r_busy <= 1'b0;
            endcase
        end else if (r_busy && i_cmd.conv) begin
            r_ph <= r_ph + 4'd1;
            unique case (r_ph)
                4'd0: r_a <= 25'(27'(r_count) + 27'(DayBias));
                4'd1: r_q <= 8'(w_qera >> 25);
                4'd2: r_r <= 19'(r_a - 25'(r_q) * 25'(EraDays));
                4'd3: if (r_r >= 19'(EraDays)) begin
                    r_r <= r_r - 19'(EraDays);
                    r_q <= r_q + 8'd1;
                end
                4'd4: begin
                    r_q2 <= 9'(w_q1460 >> 18);
                    r_c <= w_c_doe;
                end
                4'd5: r_rem <= 12'(r_r - 19'(r_q2) * 19'd1460);
                4'd6: r_t <= 18'(r_r - 19'(r_q2) + 19'(r_c)
                             - ((r_rem >= 12'd1460) ? 19'd1 : 19'd0));
                4'd7: r_q2 <= 9'(w_q365 >> 18);
                4'd8: r_rem <= 12'(r_t - 18'(r_q2) * 18'd365);
                4'd9: r_yoe <= (r_rem >= 12'd365) ? r_q2 + 9'd1 : r_q2;
                4'd10: r_base <= w_base;
                4'd11: r_doy <= 9'(r_r - 19'(r_base));
                4'd12: begin
                    r_mp <= w_mp;
                    r_year <= 16'(17'(r_yoe) + 17'(r_q) * 17'd400
                                  + 17'(w_mp >= 4'd10) - 17'(YearBias));
                end
                default: r_busy <= 1'b0;
            endcase
        end
    end

    assign o_status.done = r_busy && (r_fwd ? (r_ph == 4'd13) : (r_ph == 4'd6));
    assign o_day_count = r_count;
    assign o_cal_month = (r_mp < 4'd10) ? r_mp + 4'd3 : r_mp - 4'd9;
    assign o_cal_day   = 5'(r_doy - month_start(r_mp) + 9'd1);
    assign o_cal_year  = r_year;
endmodule

// ----- design/day_count_calendar_date_unit.sv -----
// Calendar day counter: holds days since 1970-01-01 (proleptic Gregorian),
// loaded from the start date registers at reset and after each write to
// one of them. Each request adds a signed offset and returns the saturated
// count with its year, month and day, computed by the sequencer's
// reciprocal divisions and the month lookup. A new request is taken only
// once the last result has been taken, so a waiting result holds off the
// next request. Register writes are taken only while idle, and each write
// to a start date register starts a reload in which neither channel
// accepts; the first request after reset waits for the initial load.
module day_count_calendar_date_unit import dcd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [23:0] i_day_offset,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [24:0] o_day_count,
    output logic signed [15:0] o_cal_year,
    output logic [3:0]         o_cal_month,
    output logic [4:0]         o_cal_day
);
    `include "day_count_calendar_date_unit_macros.svh"

    logic signed [15:0] r_year;
    logic [3:0] r_month;
    logic [4:0] r_day;
    logic w_cfg_we, w_hit;
    t_cmd w_cmd;
    t_status w_status;

    assign w_cfg_we = i_cfg_valid && o_cfg_ready;
    assign w_hit = w_cfg_we && (i_cfg_index == CfgYear || i_cfg_index == CfgMonth
                                || i_cfg_index == CfgDay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_year <= 16'sd1970; r_month <= 4'd1; r_day <= 5'd1;
        end else if (w_cfg_we) begin
            unique case (i_cfg_index)
                CfgYear:  r_year  <= i_cfg_data;
                CfgMonth: r_month <= i_cfg_data[3:0];
                CfgDay:   r_day   <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    dcd_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_cfg_hit(w_hit), .o_cfg_ready, .i_in_valid, .o_in_ready,
        .o_out_valid, .i_out_ready, .o_cmd(w_cmd), .i_status(w_status)
    );

    dcd_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_status(w_status),
        .i_start_year(r_year), .i_start_month(r_month), .i_start_day(r_day),
        .i_day_offset, .o_day_count, .o_cal_year, .o_cal_month, .o_cal_day
    );

    `DCU_ASSERT_IMP(a_no_accept_while_out, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `DCU_ASSERT_IMP(a_count_in_span, i_clk, i_rst_n, o_out_valid,
        o_day_count >= CountMin && o_day_count <= CountMax)
    `DCU_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_day_count))
endmodule

// ----- tb/sv/tb_day_count_calendar_date_unit.sv -----
`timescale 1ns / 1ps

module tb_day_count_calendar_date_unit;
    import dcd_pkg::*;

    typedef struct packed {
        logic signed [24:0] count;
        logic signed [15:0] year;
        logic [3:0]         month;
        logic [4:0]         day;
    } t_date_result;

    class date_scoreboard;
        t_date_result pending[$];
        longint signed   start_year;
        longint signed   start_month;
        longint signed   start_day;
        longint signed   count;
        int              errors;

        function new();
            start_year  = 1970;
            start_month = 1;
            start_day   = 1;
            errors      = 0;
            reload();
        endfunction

        function longint signed clamp(longint signed v);
            if (v < longint'(CountMin)) return longint'(CountMin);
            if (v > longint'(CountMax)) return longint'(CountMax);
            return v;
        endfunction

        function longint signed days_of_date(longint signed y, longint signed m,
                                             longint signed d);
            longint signed era, yoe, doy;
            if (m <= 2) y = y - 1;
            era = (y >= 0 ? y : y - 399) / 400;
            yoe = y - era * 400;
            doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
            return era * EraDays + yoe * 365 + yoe / 4 - yoe / 100 + doy - EpochShift;
        endfunction

        function t_date_result date_of_days(longint signed z);
            longint signed era, doe, yoe, doy, mp, y, m, d;
            t_date_result r;
            z   = z + EpochShift;
            era = (z >= 0 ? z : z - (EraDays - 1)) / EraDays;
            doe = z - era * EraDays;
            yoe = (doe - doe / 1460 + doe / 36524 - doe / (EraDays - 1)) / 365;
            doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
            mp  = (5 * doy + 2) / 153;
            d   = doy - (153 * mp + 2) / 5 + 1;
            m   = mp < 10 ? mp + 3 : mp - 9;
            y   = yoe + era * 400 + (m <= 2 ? 1 : 0);
            r.count = count[24:0];
            r.year  = y[15:0];
            r.month = m[3:0];
            r.day   = d[4:0];
            return r;
        endfunction

        function void reload();
            longint signed m;
            m = start_month;
            if (m < 1) m = 1;
            if (m > 12) m = 12;
            count = clamp(days_of_date(start_year, m, start_day));
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] data);
            case (idx)
                CfgYear:  start_year = longint'($signed(data));
                CfgMonth: start_month = longint'(data[3:0]);
                CfgDay:   start_day = longint'(data[4:0]);
                default:  return;
            endcase
            reload();
        endfunction

        function void note_request(logic signed [23:0] offset);
            count = clamp(count + longint'(offset));
            pending.push_back(date_of_days(count));
        endfunction

        function void check_result(t_date_result got);
            t_date_result want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result count=%0d", $time, got.count);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.count !== want.count) begin
                $display("%0t: day_count expected %0d actual %0d", $time, want.count,
                         got.count);
                errors++;
            end
            if (got.year !== want.year) begin
                $display("%0t: cal_year expected %0d actual %0d", $time, want.year,
                         got.year);
                errors++;
            end
            if (got.month !== want.month) begin
                $display("%0t: cal_month expected %0d actual %0d", $time, want.month,
                         got.month);
                errors++;
            end
            if (got.day !== want.day) begin
                $display("%0t: cal_day expected %0d actual %0d", $time, want.day,
                         got.day);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [23:0] i_day_offset;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [24:0] o_day_count;
    logic signed [15:0] o_cal_year;
    logic [3:0]         o_cal_month;
    logic [4:0]         o_cal_day;

    date_scoreboard sb = new();
    bit quiet_phase = 0;
    bit hold_request = 0;

    day_count_calendar_date_unit i_dut (.*);

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result('{o_day_count, o_cal_year, o_cal_month, o_cal_day});
    end

    // Receiver: random stalls, plus one long hold-off so the block backs up.
    initial begin
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                i_out_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_request = 0;
            end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_start(logic signed [15:0] y, logic [3:0] m, logic [4:0] d);
        write_reg(CfgYear, y);
        write_reg(CfgMonth, {12'd0, m});
        write_reg(CfgDay, {11'd0, d});
    endtask

    task automatic send_offset(logic signed [23:0] offset);
        if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_day_offset <= offset;
        i_in_valid   <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_request(offset);
    endtask

    // Let every outstanding request drain before touching the registers.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic signed [23:0] random_offset();
        case ($urandom_range(0, 9))
            0:       return 24'($urandom());
            1:       return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            2, 3:    return $signed(24'($urandom_range(0, 400000))) - 24'sd200000;
            default: return $signed(24'($urandom_range(0, 800))) - 24'sd400;
        endcase
    endfunction

    initial begin
        logic signed [23:0] directed[$];
        logic signed [15:0] y;
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_day_offset = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed = '{24'sd0, 24'sd1, -24'sd1, 24'sd58, 24'sd365, 24'sd366, -24'sd730,
                     24'sd10957, 24'sd146097, -24'sd146097, 24'sh7FFFFF, 24'sh7FFFFF,
                     24'sd1, 24'sh800000, 24'sh800000, 24'sh800000, -24'sd1, 24'sd31};
        foreach (directed[k]) send_offset(directed[k]);
        drain();

        // Start dates at the span edges and with rolled or clamped fields.
        set_start(-16'sd32768, 4'd1, 5'd1);
        send_offset(24'sd0);
        send_offset(-24'sd1);
        drain();
        set_start(16'sd32767, 4'd12, 5'd31);
        send_offset(24'sd0);
        send_offset(24'sd1);
        drain();
        set_start(16'sd1900, 4'd2, 5'd31);
        send_offset(24'sd0);
        drain();
        set_start(16'sd2000, 4'd3, 5'd0);
        send_offset(24'sd0);
        drain();
        set_start(16'sd2024, 4'd0, 5'd15);
        send_offset(24'sd0);
        drain();
        set_start(16'sd2024, 4'd15, 5'd31);
        send_offset(24'sd0);
        drain();
        // An index beyond the register list must not reload the count.
        write_reg(2'd3, 16'hFFFF);
        send_offset(24'sd0);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 3))
                0:       y = 16'($urandom());
                1:       y = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                default: y = $signed(16'($urandom_range(0, 4000))) - 16'sd2000;
            endcase
            set_start(y, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
            quiet_phase = (phase == 7);
            for (int n = 0; n < 195; n++) begin
                if (phase == 3 && n == 20) hold_request = 1;
                send_offset(random_offset());
            end
            drain();
        end

        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+design
design/dcd_pkg.sv
design/dcd_ctrl.sv
design/dcd_datapath.sv
design/day_count_calendar_date_unit.sv
tb/sv/tb_day_count_calendar_date_unit.sv
